[src/lprl_pkg.sv]
// Shared types and constants for the longest-prefix route lookup block.
// No dependencies; imported by longest_prefix_route_lookup.sv (lprl_ram does not import it).
package lprl_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int LIM_W       = (CNT_W > 8) ? CNT_W : 8;
    localparam int ENTRY_W     = 64;

    // Request kinds carried on s_tuser.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Register select, taken from paddr[2].
    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } state_t;

endpackage

[src/lprl_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the route table.
module lprl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/longest_prefix_route_lookup.sv]
// Top level of the IPv4 longest-prefix route lookup: stream ports, APB register,
// scan sequencer and compare unit. Depends on lprl_pkg and lprl_ram.
//
// A load request writes one route entry (network, mask) into the table in the
// cycle it is accepted and gives no result. A lookup request scans slots
// 0 .. min(entry_count, TABLE_DEPTH)-1, reading one entry per cycle from the
// table RAM through a single masked compare and mask-length compare, and
// returns its result on m_* through the output register; the next request is
// accepted only once that result has been placed in the output register, so
// the block takes no new request while a lookup is in progress. Ties on mask
// length go to the lowest slot; a miss gives match_found = 0 with all other
// fields zero. The table has no reset: only slots that were loaded may be
// scanned. entry_count sits at APB address 0 and must be written only while
// the block is idle.
module longest_prefix_route_lookup (
    input  logic         aclk,
    input  logic         aresetn,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, low bit up: entry_slot[6:0], entry_network[38:7],
    // entry_mask[70:39], lookup_address[102:71], zero pad[103]
    input  logic [103:0] s_tdata,
    // s_tuser: opcode
    input  logic         s_tuser,
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, low bit up: match_slot[6:0], match_network[38:7],
    // match_mask[70:39], zero pad[71]
    output logic [71:0]  m_tdata,
    // m_tuser: match_found
    output logic         m_tuser
);

    import lprl_pkg::*;

    state_t state_reg, state_next;

    logic [7:0]        entry_count_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]  limit_in;
    logic [LIM_W-1:0]  count_ext;
    logic [31:0]       addr_reg;
    logic              rd_valid_reg;
    logic [SLOT_W-1:0] rd_slot_reg;

    logic              found_reg;
    logic [SLOT_W-1:0] best_slot_reg;
    logic [31:0]       best_net_reg;
    logic [31:0]       best_mask_reg;

    logic              m_tvalid_reg, m_tvalid_next;
    logic              out_found_reg;
    logic [6:0]        out_slot_reg;
    logic [31:0]       out_net_reg;
    logic [31:0]       out_mask_reg;

    logic [6:0]        in_slot;
    logic [31:0]       in_net;
    logic [31:0]       in_mask;
    logic [31:0]       in_addr;
    logic              s_accept;
    logic              lookup_start;
    logic              ram_we;
    logic              ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [31:0]       rd_net;
    logic [31:0]       rd_mask;
    logic              hit;
    logic              better;
    logic              out_load;
    logic              cfg_write;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRY_COUNT);
    assign prdata    = (paddr[2] == REG_ENTRY_COUNT) ? {24'b0, entry_count_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= 8'd0;
        end else if (cfg_write) begin
            entry_count_reg <= pwdata[7:0];
        end
    end

    // ---------------- request decode ----------------
    assign in_slot  = s_tdata[6:0];
    assign in_net   = s_tdata[38:7];
    assign in_mask  = s_tdata[70:39];
    assign in_addr  = s_tdata[102:71];
    assign s_accept = s_tvalid && s_tready;
    assign lookup_start = s_accept && (s_tuser == OP_LOOKUP);
    assign ram_we   = s_accept && (s_tuser == OP_LOAD) && (32'(in_slot) < 32'(TABLE_DEPTH));

    // The scan length saturates at the table depth.
    assign count_ext = LIM_W'(entry_count_reg);
    assign limit_in  = (count_ext > LIM_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(count_ext);

    // ---------------- route table ----------------
    lprl_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (SLOT_W'(in_slot)),
        .wdata ({in_mask, in_net}),
        .re    (ram_re),
        .raddr (idx_reg[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (lookup_start) begin
                    state_next = (limit_in == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (CNT_W'(idx_reg + 1'b1) == limit_reg) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_tready = 1'b0;
        ram_re   = 1'b0;
        out_load = 1'b0;
        idx_next = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                idx_next = '0;
            end
            ST_SCAN: begin
                ram_re   = 1'b1;
                idx_next = CNT_W'(idx_reg + 1'b1);
            end
            ST_WAIT: begin
                idx_next = idx_reg;
            end
            ST_DONE: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= ram_re;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        rd_slot_reg <= idx_reg[SLOT_W-1:0];
        if (lookup_start) begin
            limit_reg <= limit_in;
            addr_reg  <= in_addr;
        end
    end

    // ---------------- shared compare unit ----------------
    assign rd_net  = ram_rdata[31:0];
    assign rd_mask = ram_rdata[63:32];
    assign hit     = (rd_net == (addr_reg & rd_mask));
    // A strictly longer mask is needed to displace an earlier match.
    assign better  = hit && (!found_reg || (rd_mask > best_mask_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (lookup_start) begin
            found_reg <= 1'b0;
        end else if (rd_valid_reg && better) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (lookup_start) begin
            best_slot_reg <= '0;
            best_net_reg  <= 32'd0;
            best_mask_reg <= 32'd0;
        end else if (rd_valid_reg && better) begin
            best_slot_reg <= rd_slot_reg;
            best_net_reg  <= rd_net;
            best_mask_reg <= rd_mask;
        end
    end

    // ---------------- output register ----------------
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_found_reg <= found_reg;
            out_slot_reg  <= 7'(best_slot_reg);
            out_net_reg   <= best_net_reg;
            out_mask_reg  <= best_mask_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {1'b0, out_mask_reg, out_net_reg, out_slot_reg};

    // ---------------- assertions ----------------
    // A read result only arrives while the scan or its drain cycle is active.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (state_reg == ST_SCAN || state_reg == ST_WAIT))
        else $error("table read data outside of a scan");

    // The scan index never runs past the saturated entry count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (idx_reg < limit_reg))
        else $error("scan index beyond entry limit");

    // A reported match must actually cover its own network under its mask.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ((m_tdata[38:7] & ~m_tdata[70:39]) == 32'd0))
        else $error("reported route has network bits outside its mask");

    // A miss carries all-zero payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 72'd0))
        else $error("miss result with nonzero payload");

    // A finished lookup is not dropped while the output register is busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && m_tvalid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("lookup left done state with output still occupied");

endmodule
